/* src/cme_pkg.sv */
// Package for the classification metrics engine: shared types, constants, FSM states.
// No dependencies.
package cme_pkg;

    localparam int MAX_LABELS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int Q_BITS         = 17;
    localparam int LABEL_BITS     = 16;
    localparam logic [16:0] Q_ONE = 17'h10000;

    localparam logic [1:0] SEL_ACCURACY  = 2'd0;
    localparam logic [1:0] SEL_PRECISION = 2'd1;
    localparam logic [1:0] SEL_RECALL    = 2'd2;
    localparam logic [1:0] SEL_FMEASURE  = 2'd3;
    localparam logic [1:0] SEL_RESET     = SEL_FMEASURE;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_P,
        ST_DIV_R,
        ST_DIV_F,
        ST_ROW,
        ST_AVG_P,
        ST_AVG_R,
        ST_AVG_F,
        ST_ACC,
        ST_SUM,
        ST_CLEAR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic count_en;     // count the accepted sample
        logic idx_clr;      // restart entry walk
        logic idx_inc;      // advance entry walk
        logic div_start;    // start the shared divider
        logic [2:0] div_op; // which quotient to form
        logic row_load;     // load class row into output register
        logic sum_load;     // load summary row into output register
        logic clear;        // clear table
    } t_cmd;

    localparam logic [2:0] OP_P   = 3'd0;
    localparam logic [2:0] OP_R   = 3'd1;
    localparam logic [2:0] OP_F   = 3'd2;
    localparam logic [2:0] OP_AVP = 3'd3;
    localparam logic [2:0] OP_AVR = 3'd4;
    localparam logic [2:0] OP_AVF = 3'd5;
    localparam logic [2:0] OP_ACC = 3'd6;

    // datapath -> controller
    typedef struct packed {
        logic idx_end;      // walk index past used entries
        logic is_class;     // current entry carries the class flag
        logic div_busy;     // divider working
        logic out_full;     // output register holds an untaken row
    } t_status;

endpackage

/* src/cme_ctrl.sv */
// Controller state machine of the classification metrics engine.
// Depends on cme_pkg.
module cme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_in_last,
    input  cme_pkg::t_status  i_status,
    output logic              o_in_ready,
    output cme_pkg::t_cmd     o_cmd
);
    cme_pkg::t_state r_state, n_state;
    logic r_div_wait, n_div_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cme_pkg::ST_IDLE;
            r_div_wait <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_div_wait <= n_div_wait;
        end
    end

    // divider done when launched and no longer busy
    logic w_div_done;
    assign w_div_done = r_div_wait && !i_status.div_busy;

    always_comb begin
        n_state    = r_state;
        n_div_wait = r_div_wait;
        case (r_state)
            cme_pkg::ST_IDLE: begin
                if (i_in_fire && i_in_last) n_state = cme_pkg::ST_SCAN;
            end
            cme_pkg::ST_SCAN: begin
                if (i_status.idx_end) begin
                    n_state = cme_pkg::ST_AVG_P;
                    n_div_wait = 1'b1;
                end else if (i_status.is_class) begin
                    n_state = cme_pkg::ST_DIV_P;
                    n_div_wait = 1'b1;
                end
            end
            cme_pkg::ST_DIV_P: if (w_div_done) n_state = cme_pkg::ST_DIV_R;
            cme_pkg::ST_DIV_R: if (w_div_done) n_state = cme_pkg::ST_DIV_F;
            cme_pkg::ST_DIV_F: if (w_div_done) begin
                n_state = cme_pkg::ST_ROW;
                n_div_wait = 1'b0;
            end
            cme_pkg::ST_ROW: if (!i_status.out_full) n_state = cme_pkg::ST_SCAN;
            cme_pkg::ST_AVG_P: if (w_div_done) n_state = cme_pkg::ST_AVG_R;
            cme_pkg::ST_AVG_R: if (w_div_done) n_state = cme_pkg::ST_AVG_F;
            cme_pkg::ST_AVG_F: if (w_div_done) n_state = cme_pkg::ST_ACC;
            cme_pkg::ST_ACC: if (w_div_done) begin
                n_state = cme_pkg::ST_SUM;
                n_div_wait = 1'b0;
            end
            cme_pkg::ST_SUM: if (!i_status.out_full) n_state = cme_pkg::ST_CLEAR;
            cme_pkg::ST_CLEAR: n_state = cme_pkg::ST_IDLE;
            default: n_state = cme_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == cme_pkg::ST_IDLE);
        o_cmd = '0;
        o_cmd.count_en = i_in_fire;
        case (r_state)
            cme_pkg::ST_IDLE: o_cmd.idx_clr = 1'b1;
            cme_pkg::ST_SCAN: begin
                if (i_status.idx_end) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op = cme_pkg::OP_AVP;
                end else if (i_status.is_class) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op = cme_pkg::OP_P;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            cme_pkg::ST_DIV_P: begin
                o_cmd.div_start = w_div_done;
                o_cmd.div_op = cme_pkg::OP_R;
            end
            cme_pkg::ST_DIV_R: begin
                o_cmd.div_start = w_div_done;
                o_cmd.div_op = cme_pkg::OP_F;
            end
            cme_pkg::ST_ROW: begin
                o_cmd.row_load = !i_status.out_full;
                o_cmd.idx_inc = !i_status.out_full;
            end
            cme_pkg::ST_AVG_P: begin
                o_cmd.div_start = w_div_done;
                o_cmd.div_op = cme_pkg::OP_AVR;
            end
            cme_pkg::ST_AVG_R: begin
                o_cmd.div_start = w_div_done;
                o_cmd.div_op = cme_pkg::OP_AVF;
            end
            cme_pkg::ST_AVG_F: begin
                o_cmd.div_start = w_div_done;
                o_cmd.div_op = cme_pkg::OP_ACC;
            end
            cme_pkg::ST_SUM: o_cmd.sum_load = !i_status.out_full;
            cme_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            default: ;
        endcase
    end
endmodule

/* src/cme_div.sv */
// Restoring divider, one quotient bit per cycle, for the metrics engine.
// Depends on nothing; widths come from parameters.
module cme_div #(
    parameter int NUM_BITS = 49,
    parameter int DEN_BITS = 32,
    parameter int QUO_BITS = 49
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_busy,
    output logic [QUO_BITS-1:0] o_quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   w_shift;
    logic [DEN_BITS:0]   w_diff;

    assign w_shift = {r_rem[DEN_BITS-1:0], r_num[NUM_BITS-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(NUM_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) r_busy <= 1'b0;
        end
    end

    // quotient bits shift into r_num as the numerator shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_diff[DEN_BITS]) begin
                r_rem <= w_diff;
                r_num <= {r_num[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_num <= {r_num[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = QUO_BITS'(r_num);
endmodule

/* src/cme_dp.sv */
// Datapath of the metrics engine: label table, counters, divider, output register.
// Depends on cme_pkg and cme_div.
module cme_dp #(
    parameter int MAX_LABELS = cme_pkg::MAX_LABELS_DEF,
    parameter int COUNT_BITS = cme_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cme_pkg::t_cmd         i_cmd,
    output cme_pkg::t_status      o_status,
    input  logic [15:0]           i_true_label,
    input  logic [15:0]           i_pred_label,
    input  logic [1:0]            i_metric_select,
    output logic                  o_row_valid,
    input  logic                  i_row_ready,
    output logic [15:0]           o_class_code,
    output logic [16:0]           o_precision_q,
    output logic [16:0]           o_recall_q,
    output logic [16:0]           o_fmeasure_q,
    output logic [16:0]           o_accuracy_q,
    output logic [16:0]           o_selected_average,
    output logic                  o_zero_divide,
    output logic                  o_table_full,
    output logic                  o_is_summary
);
    localparam int IDX_BITS = $clog2(MAX_LABELS);
    localparam int USE_BITS = $clog2(MAX_LABELS + 1);
    localparam int SUM_BITS = 17 + USE_BITS;
    localparam int HIT_BITS = COUNT_BITS + USE_BITS;
    localparam int NUM_BITS = (HIT_BITS + 17 > 36) ? HIT_BITS + 17 : 36;
    localparam int DEN_BITS = (COUNT_BITS > 18) ? COUNT_BITS : 18;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [15:0]           r_code [MAX_LABELS];
    logic                  r_cls  [MAX_LABELS];
    logic [COUNT_BITS-1:0] r_tcnt [MAX_LABELS];
    logic [COUNT_BITS-1:0] r_pcnt [MAX_LABELS];
    logic [COUNT_BITS-1:0] r_hcnt [MAX_LABELS];
    logic [USE_BITS-1:0]   r_used;
    logic [COUNT_BITS-1:0] r_samples;
    logic                  r_ovf;

    // lookup: parallel compare against used entries
    logic [MAX_LABELS-1:0] w_thit, w_phit;
    logic                  w_tfound, w_pfound, w_same;
    logic [IDX_BITS-1:0]   w_tidx, w_pidx;
    logic                  w_tok, w_pok, w_tnew, w_pnew;
    logic [USE_BITS-1:0]   w_used1;

    always_comb begin
        w_thit = '0;
        w_phit = '0;
        w_tidx = '0;
        w_pidx = '0;
        for (int k = 0; k < MAX_LABELS; k++) begin
            w_thit[k] = (USE_BITS'(k) < r_used) && (r_code[k] == i_true_label);
            w_phit[k] = (USE_BITS'(k) < r_used) && (r_code[k] == i_pred_label);
        end
        for (int k = MAX_LABELS - 1; k >= 0; k--) begin
            if (w_thit[k]) w_tidx = IDX_BITS'(k);
            if (w_phit[k]) w_pidx = IDX_BITS'(k);
        end
        w_tfound = |w_thit;
        w_pfound = |w_phit;
        w_same   = (i_true_label == i_pred_label);
        w_tnew   = !w_tfound && (r_used < USE_BITS'(MAX_LABELS));
        w_tok    = w_tfound || w_tnew;
        if (w_tnew) w_tidx = IDX_BITS'(r_used);
        w_used1  = r_used + USE_BITS'(w_tnew);
        if (w_same) begin
            w_pok  = w_tok;
            w_pnew = 1'b0;
            w_pidx = w_tidx;
        end else begin
            w_pnew = !w_pfound && (w_used1 < USE_BITS'(MAX_LABELS));
            w_pok  = w_pfound || w_pnew;
            if (w_pnew) w_pidx = IDX_BITS'(w_used1);
        end
    end

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.count_en) begin
            if (w_tnew) r_code[w_tidx] <= i_true_label;
            if (w_pnew) r_code[w_pidx] <= i_pred_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < MAX_LABELS; k++) begin
                r_cls[k]  <= 1'b0;
                r_tcnt[k] <= '0;
                r_pcnt[k] <= '0;
                r_hcnt[k] <= '0;
            end
            r_used    <= '0;
            r_samples <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.count_en) begin
            r_samples <= sat_inc(r_samples);
            r_used    <= w_used1 + USE_BITS'(w_pnew);
            if (!w_tok || !w_pok) r_ovf <= 1'b1;
            if (w_tok) begin
                r_cls[w_tidx]  <= 1'b1;
                r_tcnt[w_tidx] <= sat_inc(r_tcnt[w_tidx]);
                if (w_same) r_hcnt[w_tidx] <= sat_inc(r_hcnt[w_tidx]);
            end
            if (w_pok) r_pcnt[w_pidx] <= sat_inc(r_pcnt[w_pidx]);
        end
    end

    // walk over entries for the emit phase
    logic [USE_BITS-1:0] r_idx;
    logic [IDX_BITS-1:0] w_ix;
    assign w_ix = r_idx[IDX_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.idx_clr) r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + 1'b1;
    end

    // accumulators and per-row results
    logic [16:0]          r_p, r_r, r_f, r_avp, r_avr, r_avf, r_acc;
    logic                 r_zd, r_zds;
    logic [SUM_BITS-1:0]  r_sp, r_sr, r_sf;
    logic [HIT_BITS-1:0]  r_shit;
    logic [USE_BITS-1:0]  r_ncls;
    logic [2:0]           r_op;
    logic                 r_pend;

    // divider operands
    logic [NUM_BITS-1:0] w_num, w_rnum;
    logic [DEN_BITS-1:0] w_den;
    logic                w_zero, w_one;
    logic [COUNT_BITS-1:0] w_h, w_d;
    logic [HIT_BITS-1:0] w_hc;
    logic [17:0]         w_pr;
    logic [35:0]         w_prod;
    logic [16:0]         w_rcur;

    assign w_hc   = (r_shit > HIT_BITS'(r_samples)) ? HIT_BITS'(r_samples) : r_shit;

    always_comb begin
        w_num  = '0;
        w_den  = '0;
        w_zero = 1'b0;
        w_one  = 1'b0;
        w_h    = r_hcnt[w_ix];
        w_d    = '0;
        case (i_cmd.div_op)
            cme_pkg::OP_P, cme_pkg::OP_R: begin
                w_d    = (i_cmd.div_op == cme_pkg::OP_P) ? r_pcnt[w_ix] : r_tcnt[w_ix];
                w_num  = NUM_BITS'({w_h, 16'h0});
                w_den  = DEN_BITS'(w_d);
                w_zero = (w_d == '0);
                w_one  = (w_h >= w_d);
            end
            cme_pkg::OP_F: begin
                w_num  = NUM_BITS'({w_prod, 1'b0});
                w_den  = DEN_BITS'(w_pr);
                w_zero = (w_pr == '0);
            end
            cme_pkg::OP_AVP, cme_pkg::OP_AVR, cme_pkg::OP_AVF: begin
                w_num  = (i_cmd.div_op == cme_pkg::OP_AVP) ? NUM_BITS'(r_sp) :
                         (i_cmd.div_op == cme_pkg::OP_AVR) ? NUM_BITS'(r_sr) :
                                                             NUM_BITS'(r_sf);
                w_den  = DEN_BITS'(r_ncls);
                w_zero = (r_ncls == '0);
            end
            cme_pkg::OP_ACC: begin
                w_num  = NUM_BITS'({w_hc, 16'h0});
                w_den  = DEN_BITS'(r_samples);
                w_zero = (r_samples == '0);
                w_one  = (w_hc >= HIT_BITS'(r_samples));
            end
            default: ;
        endcase
        w_rnum = (w_zero || w_one) ? '0 : w_num;
    end

    logic                w_busy;
    logic [NUM_BITS-1:0] w_quo;
    logic                r_special, r_sone;

    cme_div #(
        .NUM_BITS(NUM_BITS),
        .DEN_BITS(DEN_BITS),
        .QUO_BITS(NUM_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_rnum),
        .i_den  (w_zero ? DEN_BITS'(1) : w_den),
        .o_busy (w_busy),
        .o_quo  (w_quo)
    );

    logic [16:0] w_q;
    assign w_q = r_sone ? cme_pkg::Q_ONE : (r_special ? 17'd0 : w_quo[16:0]);

    // F starts on the edge that captures recall, so take recall straight from the divider
    assign w_rcur = (r_pend && !w_busy && r_op == cme_pkg::OP_R) ? w_q : r_r;
    assign w_pr   = {1'b0, r_p} + {1'b0, w_rcur};
    assign w_prod = 36'(r_p) * 36'(w_rcur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.div_start) r_pend <= 1'b1;
            else if (r_pend && !w_busy) r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_sp   <= '0;
            r_sr   <= '0;
            r_sf   <= '0;
            r_shit <= '0;
            r_ncls <= '0;
        end
        if (i_cmd.div_start) begin
            r_op      <= i_cmd.div_op;
            r_special <= w_zero;
            r_sone    <= w_one && !w_zero;
            if (i_cmd.div_op == cme_pkg::OP_P) r_zd <= w_zero;
            else if (w_zero && i_cmd.div_op != cme_pkg::OP_AVR
                     && i_cmd.div_op != cme_pkg::OP_AVF) begin
                if (i_cmd.div_op == cme_pkg::OP_AVP || i_cmd.div_op == cme_pkg::OP_ACC)
                    r_zds <= 1'b1;
                else
                    r_zd <= 1'b1;
            end
            if (i_cmd.div_op == cme_pkg::OP_AVP) r_zds <= w_zero;
        end
        if (r_pend && !w_busy && !i_cmd.div_start || (r_pend && !w_busy && i_cmd.div_start)) begin
            case (r_op)
                cme_pkg::OP_P:   r_p   <= w_q;
                cme_pkg::OP_R:   r_r   <= w_q;
                cme_pkg::OP_F:   r_f   <= w_q;
                cme_pkg::OP_AVP: r_avp <= w_q;
                cme_pkg::OP_AVR: r_avr <= w_q;
                cme_pkg::OP_AVF: r_avf <= w_q;
                cme_pkg::OP_ACC: r_acc <= w_q;
                default: ;
            endcase
        end
        if (i_cmd.row_load) begin
            r_sp   <= r_sp + SUM_BITS'(r_p);
            r_sr   <= r_sr + SUM_BITS'(r_r);
            r_sf   <= r_sf + SUM_BITS'(r_f);
            r_shit <= r_shit + HIT_BITS'(r_hcnt[w_ix]);
            r_ncls <= r_ncls + 1'b1;
        end
    end

    // output register
    logic r_ov;
    logic [16:0] w_sel;
    always_comb begin
        case (i_metric_select)
            cme_pkg::SEL_ACCURACY:  w_sel = r_acc;
            cme_pkg::SEL_PRECISION: w_sel = r_avp;
            cme_pkg::SEL_RECALL:    w_sel = r_avr;
            default:                w_sel = r_avf;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_cmd.row_load || i_cmd.sum_load) r_ov <= 1'b1;
        else if (i_row_ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_load) begin
            o_class_code       <= r_code[w_ix];
            o_precision_q      <= r_p;
            o_recall_q         <= r_r;
            o_fmeasure_q       <= r_f;
            o_accuracy_q       <= '0;
            o_selected_average <= '0;
            o_zero_divide      <= r_zd;
            o_table_full       <= r_ovf;
            o_is_summary       <= 1'b0;
        end else if (i_cmd.sum_load) begin
            o_class_code       <= '0;
            o_precision_q      <= r_avp;
            o_recall_q         <= r_avr;
            o_fmeasure_q       <= r_avf;
            o_accuracy_q       <= r_acc;
            o_selected_average <= w_sel;
            o_zero_divide      <= r_zds;
            o_table_full       <= r_ovf;
            o_is_summary       <= 1'b1;
        end
    end

    assign o_row_valid       = r_ov;
    assign o_status.idx_end  = (r_idx >= r_used);
    assign o_status.is_class = r_cls[w_ix];
    assign o_status.div_busy = w_busy;
    assign o_status.out_full = r_ov && !i_row_ready;
endmodule

/* src/classification_metrics_engine_unit.sv */
// Classification metrics engine: per-class and macro-averaged precision, recall, F1; accuracy per run.
// Counting: one sample per cycle, lookup against all table entries in parallel.
// Emit after the last sample: per class three divisions on one bit-serial divider,
// then four more for the summary row; input stalls meanwhile.
// Reset (synchronous, active low) clears the table, counters and sets metric_select to 3.
// Depends on cme_pkg, cme_ctrl, cme_dp, cme_div.
module classification_metrics_engine_unit #(
    parameter int MAX_LABELS = cme_pkg::MAX_LABELS_DEF,
    parameter int COUNT_BITS = cme_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] true_label, [31:16] pred_label
    input  logic        s_axis_tlast,  // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] class_code, [32:16] precision_q, [49:33] recall_q, [66:50] fmeasure_q,
    // [83:67] accuracy_q, [100:84] selected_average, [101] zero_divide, [102] table_full
    output logic [103:0] m_axis_tdata,
    output logic        m_axis_tuser,  // is_summary
    output logic        m_axis_tlast,  // last_row
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [1:0] r_metric_select;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_metric_select <= cme_pkg::SEL_RESET;
        else if (psel && penable && pwrite && paddr == 1'b0) r_metric_select <= pwdata[1:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {30'd0, r_metric_select} : 32'd0;

    cme_pkg::t_cmd    w_cmd;
    cme_pkg::t_status w_status;
    logic             w_fire;
    logic             w_is_sum;

    assign w_fire = s_axis_tvalid && s_axis_tready;

    cme_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (w_fire),
        .i_in_last (s_axis_tlast),
        .i_status  (w_status),
        .o_in_ready(s_axis_tready),
        .o_cmd     (w_cmd)
    );

    cme_dp #(
        .MAX_LABELS(MAX_LABELS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_true_label      (s_axis_tdata[15:0]),
        .i_pred_label      (s_axis_tdata[31:16]),
        .i_metric_select   (r_metric_select),
        .o_row_valid       (m_axis_tvalid),
        .i_row_ready       (m_axis_tready),
        .o_class_code      (m_axis_tdata[15:0]),
        .o_precision_q     (m_axis_tdata[32:16]),
        .o_recall_q        (m_axis_tdata[49:33]),
        .o_fmeasure_q      (m_axis_tdata[66:50]),
        .o_accuracy_q      (m_axis_tdata[83:67]),
        .o_selected_average(m_axis_tdata[100:84]),
        .o_zero_divide     (m_axis_tdata[101]),
        .o_table_full      (m_axis_tdata[102]),
        .o_is_summary      (w_is_sum)
    );

    assign m_axis_tdata[103] = 1'b0;
    assign m_axis_tuser = w_is_sum;
    assign m_axis_tlast = w_is_sum;
endmodule

/* tb/tb_classification_metrics_engine_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for classification_metrics_engine_unit: label pairs in, metric rows out.
// Predicts rows with a scoreboard class and checks every transfer; depends on cme_pkg and the RTL.
module tb_classification_metrics_engine_unit;

    localparam int WATCHDOG_LIMIT = 20000;

    // One metric row as the block presents it.
    typedef struct packed {
        logic        last_row;
        logic        is_summary;
        logic        table_full;
        logic        zero_divide;
        logic [16:0] selected_average;
        logic [16:0] accuracy_q;
        logic [16:0] fmeasure_q;
        logic [16:0] recall_q;
        logic [16:0] precision_q;
        logic [15:0] class_code;
    } t_row;

    // Scoreboard: mirror of the label table and the queue of rows it predicts.
    class metrics_scoreboard;
        logic [15:0] codes[16];
        bit          is_class[16];
        longint      n_true[16];
        longint      n_pred[16];
        longint      n_hit[16];
        int          used;
        longint      samples;
        bit          overflow;
        logic [1:0]  avg_sel;
        t_row        pending_rows[$];
        int          errors;

        function new();
            avg_sel = cme_pkg::SEL_RESET;
            errors  = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < 16; i++) begin
                is_class[i] = 0;
                n_true[i]   = 0;
                n_pred[i]   = 0;
                n_hit[i]    = 0;
            end
            used     = 0;
            samples  = 0;
            overflow = 0;
        endfunction

        function longint bump(longint v);
            return (v >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v + 1;
        endfunction

        function int lookup(logic [15:0] code);
            for (int i = 0; i < used; i++)
                if (codes[i] == code) return i;
            if (used >= 16) begin
                overflow = 1;
                return -1;
            end
            codes[used]    = code;
            is_class[used] = 0;
            n_true[used]   = 0;
            n_pred[used]   = 0;
            n_hit[used]    = 0;
            used++;
            return used - 1;
        endfunction

        function longint ratio_q(longint num, longint den, ref bit zd);
            if (den == 0) begin
                zd = 1;
                return 0;
            end
            if (num >= den) return 65536;
            return (num * 65536) / den;
        endfunction

        // Count one accepted sample; on the last sample predict the rows and clear.
        function void note_sample(logic [15:0] t_code, logic [15:0] p_code, bit last);
            int     ti;
            int     pi;
            int     classes;
            longint sp, sr, sf, sh, p, r, f, ap, ar, af, acc, sel;
            bit     zd, zd_sum;
            t_row   row;
            ti = lookup(t_code);
            pi = lookup(p_code);
            samples = bump(samples);
            if (ti >= 0) begin
                is_class[ti] = 1;
                n_true[ti] = bump(n_true[ti]);
                if (t_code == p_code) n_hit[ti] = bump(n_hit[ti]);
            end
            if (pi >= 0) n_pred[pi] = bump(n_pred[pi]);
            if (!last) return;
            classes = 0;
            sp = 0; sr = 0; sf = 0; sh = 0;
            ap = 0; ar = 0; af = 0;
            zd_sum = 0;
            for (int i = 0; i < used; i++) begin
                if (!is_class[i]) continue;
                zd = 0;
                p = ratio_q(n_hit[i], n_pred[i], zd);
                r = ratio_q(n_hit[i], n_true[i], zd);
                if (p + r == 0) begin
                    zd = 1;
                    f  = 0;
                end else begin
                    f = (2 * p * r) / (p + r);
                end
                sp += p; sr += r; sf += f; sh += n_hit[i];
                classes++;
                row = '0;
                row.class_code  = codes[i];
                row.precision_q = p[16:0];
                row.recall_q    = r[16:0];
                row.fmeasure_q  = f[16:0];
                row.zero_divide = zd;
                row.table_full  = overflow;
                pending_rows.push_back(row);
            end
            if (classes == 0) begin
                zd_sum = 1;
            end else begin
                ap = sp / classes;
                ar = sr / classes;
                af = sf / classes;
            end
            if (sh > samples) sh = samples;
            acc = ratio_q(sh, samples, zd_sum);
            case (avg_sel)
                cme_pkg::SEL_ACCURACY:  sel = acc;
                cme_pkg::SEL_PRECISION: sel = ap;
                cme_pkg::SEL_RECALL:    sel = ar;
                default:                sel = af;
            endcase
            row = '0;
            row.precision_q      = ap[16:0];
            row.recall_q         = ar[16:0];
            row.fmeasure_q       = af[16:0];
            row.accuracy_q       = acc[16:0];
            row.selected_average = sel[16:0];
            row.zero_divide      = zd_sum;
            row.table_full       = overflow;
            row.is_summary       = 1;
            row.last_row         = 1;
            pending_rows.push_back(row);
            clear();
        endfunction

        function void check_row(t_row got);
            t_row exp_row;
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_row = pending_rows.pop_front();
            if (got !== exp_row) begin
                $display("%0t: row mismatch, expected %h, actual %h", $time, exp_row, got);
                $display("%0t:   code exp %h act %h  P %h/%h  R %h/%h  F %h/%h", $time,
                         exp_row.class_code, got.class_code, exp_row.precision_q,
                         got.precision_q, exp_row.recall_q, got.recall_q,
                         exp_row.fmeasure_q, got.fmeasure_q);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [0:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    metrics_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  out_stall_mode = 0;   // when set, the receiver draws random stalls

    classification_metrics_engine_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // Output side: check each transfer at the rising edge, draw stall at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_row({m_axis_tlast, m_axis_tuser, m_axis_tdata[102:0]});
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = out_stall_mode ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            // hold ready until a transfer happens
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("classification_metrics_engine_unit regression: fail");
            $finish;
        end
    end

    // Send one sample, with a random lead gap when asked; valid stays up after the
    // transfer and drops at the next gap or when the caller drains.
    task automatic send_sample(logic [15:0] t_code, logic [15:0] p_code, bit last, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {p_code, t_code};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(t_code, p_code, last);
        @(negedge i_clk);
    endtask

    // APB write: setup then access phase; register updates at the access edge.
    task automatic write_select(logic [1:0] sel);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= {30'd0, sel};
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        sb.avg_sel = sel;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Drop valid, wait for every predicted row, then give the emit engine time to settle.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_rows.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // One run of samples drawn from a pool of codes, ending with a last sample.
    task automatic random_run(int len, int pool, bit gaps);
        logic [15:0] base;
        logic [15:0] t_code, p_code;
        base = 16'($urandom);
        for (int k = 0; k < len; k++) begin
            t_code = base + 16'($urandom_range(0, pool - 1));
            // mostly hits, sometimes confused with a neighbour, rarely full noise
            case ($urandom_range(0, 9))
                0:       p_code = 16'($urandom);
                1, 2, 3: p_code = base + 16'($urandom_range(0, pool - 1));
                default: p_code = t_code;
            endcase
            send_sample(t_code, p_code, k == len - 1, gaps);
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extreme codes, reset select (F-measure), no stalls.
        send_sample(16'h8000, 16'h7FFF, 0, 0);
        send_sample(16'h7FFF, 16'h7FFF, 0, 0);
        send_sample(16'hFFFF, 16'h0000, 0, 0);
        send_sample(16'h0000, 16'h0000, 1, 0);
        drain();
        // single sample miss: predicted-only entry, class with zero precision and F1
        write_select(cme_pkg::SEL_ACCURACY);
        send_sample(16'h0005, 16'h0006, 1, 0);
        drain();
        // table overflow: 20 distinct true labels, all hits
        write_select(cme_pkg::SEL_PRECISION);
        for (int k = 0; k < 20; k++)
            send_sample(16'(16'h0100 + k), 16'(16'h0100 + k), k == 19, 0);
        drain();
        // a label first seen as a prediction, then as a truth
        write_select(cme_pkg::SEL_RECALL);
        send_sample(16'h0001, 16'h0002, 0, 0);
        send_sample(16'h0002, 16'h0002, 0, 0);
        send_sample(16'h0003, 16'h0001, 1, 0);
        drain();

        // Random runs with idling on both sides, select changed between runs.
        out_stall_mode = 1;
        for (int run = 0; run < 14; run++) begin
            write_select(2'(run % 4));
            random_run($urandom_range(2, 18), (run % 5 == 4) ? 20 : $urandom_range(1, 8),
                       run % 3 != 2);
            drain();
        end
        write_select(cme_pkg::SEL_FMEASURE);
        random_run(6, 3, 1);
        drain();

        if (sb.errors == 0 && sb.pending_rows.size() == 0)
            $display("classification_metrics_engine_unit regression: pass");
        else
            $display("classification_metrics_engine_unit regression: fail");
        $finish;
    end
endmodule
